@@ src/zero_padded_box_sum_2d_assert.svh @@
// ---------------------------------------------------------------------------
// zero_padded_box_sum_2d assertion macros
// shorthand for the concurrent checks used by the port checker
// ---------------------------------------------------------------------------
`ifndef ZERO_PADDED_BOX_SUM_2D_ASSERT_SVH
`define ZERO_PADDED_BOX_SUM_2D_ASSERT_SVH

// same-cycle implication, masked during reset
`define ZPBS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define ZPBS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, live through reset
`define ZPBS_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/zpbs_pkg.sv @@
// ---------------------------------------------------------------------------
// zpbs_pkg
// shared types and constants of the zero padded box sum block
// ---------------------------------------------------------------------------
package zpbs_pkg;

   // control register map
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 7;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIUS     = 2'd1;

   localparam int LINE_WIDTH_BITS = 7;
   localparam int RADIUS_BITS     = 3;
   localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 7'd20;
   localparam logic [RADIUS_BITS-1:0]     RADIUS_RESET     = 3'd1;

   // row numbers wrap at this width
   localparam int ROW_BITS = 16;

   // item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_LAST,
      ST_EMIT
   } state_type;

endpackage

@@ src/zero_padded_box_sum_2d.sv @@
// ---------------------------------------------------------------------------
// zero_padded_box_sum_2d
// streamed 2d box sum with zero padding at the frame edges
// ---------------------------------------------------------------------------
// Pixels of a row-major frame arrive one per transfer; each centre pixel gets
// the sum of its (2*radius+1)^2 window, positions outside the frame taken as
// zero, once the pixel radius rows and radius columns later has arrived.
// Drain items push out the remaining results. An item that yields no result
// is only accepted; one that yields a result then passes through address
// set-up, one window tap per cycle from the single read port of the history
// memory, final accumulate and output load. The next item is taken while a
// finished result still waits in the output register. A write
// to either control register restarts the stream. No clearing pass is needed
// after reset: a fill count marks which history entries hold pixels.
// ---------------------------------------------------------------------------
module zero_padded_box_sum_2d
   import zpbs_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_RADIUS = 4,
   parameter int PIXEL_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic signed [PIXEL_BITS-1:0]  req_pixel,
   input  logic                          req_frame_start,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [PIXEL_BITS+$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1))-1:0]
                                         rsp_window_sum,
   output logic [ROW_BITS-1:0]           rsp_out_row,
   output logic [$clog2(MAX_WIDTH)-1:0]  rsp_out_col,
   // control registers
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int SPAN_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
   localparam int HIST     = 2 * SPAN_MAX + 1;
   localparam int ADDR_W   = $clog2(HIST);
   localparam int FILL_W   = $clog2(HIST + 1);
   localparam int PEND_W   = $clog2(SPAN_MAX + 2);
   localparam int SPAN_W   = $clog2(SPAN_MAX + 1);
   localparam int WW       = $clog2(MAX_WIDTH + 1);
   localparam int RW       = $clog2(MAX_RADIUS + 1);
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int K_W      = $clog2(2 * MAX_RADIUS + 1);
   localparam int X_W      = $clog2(HIST + 1) + 2;
   localparam int SUM_BITS = PIXEL_BITS + $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1));

   // configuration
   logic [LINE_WIDTH_BITS-1:0] line_width_ff, line_width_in;
   logic [RADIUS_BITS-1:0]     radius_ff, radius_in;
   logic [WW-1:0]              w_eff;
   logic [RW-1:0]              r_eff;
   logic [SPAN_W-1:0]          span;

   // stream position
   state_type                  state_ff, state_in;
   logic [ADDR_W-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [PEND_W-1:0]          pend_ff, pend_in;
   logic [COL_W-1:0]           in_col_ff, in_col_in;
   logic [ROW_BITS-1:0]        in_row_ff, in_row_in;
   logic                       frame_ended_ff, frame_ended_in;
   logic [COL_W-1:0]           ctr_col_ff, ctr_col_in;
   logic [ROW_BITS-1:0]        ctr_row_ff, ctr_row_in;

   // window walk
   logic [PEND_W-1:0]          cen_age_ff, cen_age_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic signed [X_W-1:0]      age_ff, age_in;
   logic signed [X_W-1:0]      col_ff, col_in;
   logic [K_W-1:0]             ki_ff, ki_in;
   logic [K_W-1:0]             kj_ff, kj_in;
   logic                       rd_ok_ff, rd_ok_in;
   logic [SUM_BITS-1:0]        acc_ff, acc_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]        rsp_sum_ff, rsp_sum_in;
   logic [ROW_BITS-1:0]        rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]           rsp_col_ff, rsp_col_in;

   // memory port
   logic                       mem_we;
   logic [PIXEL_BITS-1:0]      mem_rdata;

   // scratch
   logic                       req_fire;
   logic                       csr_fire;
   logic                       restart;
   logic [PEND_W-1:0]          pend0;
   logic [PEND_W-1:0]          pend1;
   logic [FILL_W-1:0]          fill0;
   logic [COL_W-1:0]           in_col0;
   logic [ROW_BITS-1:0]        in_row0;
   logic [X_W-1:0]             start_raw;
   logic signed [X_W-1:0]      step;
   logic signed [X_W-1:0]      addr_sum;
   logic [K_W-1:0]             two_r;
   logic                       out_free;

   // effective configuration, out-of-range values clamped
   always_comb begin
      if (line_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(line_width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(line_width_ff);
      end
      if (radius_ff == '0) begin
         r_eff = RW'(1);
      end else if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(radius_ff);
      end
      span  = SPAN_W'(r_eff) * SPAN_W'(w_eff) + SPAN_W'(r_eff);
      two_r = K_W'({r_eff, 1'b0});
   end

   assign req_fire  = req_valid && !req_stall;
   assign csr_fire  = csr_valid && csr_ready;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign restart = req_frame_start || ((req_kind == KIND_PIXEL) && frame_ended_ff);
   assign pend0   = restart ? '0 : pend_ff;
   assign pend1   = pend0 + PEND_W'(1);
   assign fill0   = restart ? '0 : fill_ff;
   assign in_col0 = restart ? '0 : in_col_ff;
   assign in_row0 = restart ? '0 : in_row_ff;
   assign mem_we  = req_fire && (req_kind == KIND_PIXEL);

   // history slot of the top-left tap, before wrap reduction
   assign start_raw = X_W'(head_ff) + X_W'(2 * HIST - 1) - X_W'(cen_age_ff) - X_W'(span);

   // next tap address step along the window
   always_comb begin
      if (ki_ff == two_r) begin
         step = $signed(X_W'(w_eff)) - $signed(X_W'(two_r));
      end else begin
         step = X_W'(1);
      end
      addr_sum = $signed(X_W'(addr_ff)) + step;
      if (addr_sum < 0) begin
         addr_sum = addr_sum + $signed(X_W'(HIST));
      end else if (addr_sum >= $signed(X_W'(HIST))) begin
         addr_sum = addr_sum - $signed(X_W'(HIST));
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      line_width_in  = line_width_ff;
      radius_in      = radius_ff;
      head_in        = head_ff;
      fill_in        = fill_ff;
      pend_in        = pend_ff;
      in_col_in      = in_col_ff;
      in_row_in      = in_row_ff;
      frame_ended_in = frame_ended_ff;
      ctr_col_in     = ctr_col_ff;
      ctr_row_in     = ctr_row_ff;
      cen_age_in     = cen_age_ff;
      addr_in        = addr_ff;
      age_in         = age_ff;
      col_in         = col_ff;
      ki_in          = ki_ff;
      kj_in          = kj_ff;
      rd_ok_in       = 1'b0;
      acc_in         = rd_ok_ff ? acc_ff + SUM_BITS'(signed'(mem_rdata)) : acc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_sum_in     = rsp_sum_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               if (csr_index == REG_LINE_WIDTH) begin
                  line_width_in = LINE_WIDTH_BITS'(csr_wdata);
               end else if (csr_index == REG_RADIUS) begin
                  radius_in = RADIUS_BITS'(csr_wdata);
               end
               if ((csr_index == REG_LINE_WIDTH) || (csr_index == REG_RADIUS)) begin
                  fill_in        = '0;
                  pend_in        = '0;
                  in_col_in      = '0;
                  in_row_in      = '0;
                  frame_ended_in = 1'b0;
                  ctr_col_in     = '0;
                  ctr_row_in     = '0;
               end
            end else if (req_fire) begin
               fill_in        = fill0;
               pend_in        = pend0;
               in_col_in      = in_col0;
               in_row_in      = in_row0;
               frame_ended_in = restart ? 1'b0 : frame_ended_ff;
               if (restart) begin
                  ctr_col_in = '0;
                  ctr_row_in = '0;
               end
               if (req_kind == KIND_DRAIN) begin
                  if (pend0 != '0) begin
                     frame_ended_in = 1'b1;
                     cen_age_in     = pend0 - PEND_W'(1);
                     pend_in        = pend0 - PEND_W'(1);
                     state_in       = ST_SETUP;
                  end
               end else begin
                  head_in = (head_ff == ADDR_W'(HIST - 1)) ? '0 : head_ff + ADDR_W'(1);
                  if (fill0 < FILL_W'(HIST)) begin
                     fill_in = fill0 + FILL_W'(1);
                  end
                  if (WW'(in_col0) + WW'(1) >= w_eff) begin
                     in_col_in = '0;
                     in_row_in = in_row0 + ROW_BITS'(1);
                  end else begin
                     in_col_in = in_col0 + COL_W'(1);
                  end
                  if (pend1 > PEND_W'(span)) begin
                     cen_age_in = pend0;
                     pend_in    = pend0;
                     state_in   = ST_SETUP;
                  end else begin
                     pend_in = pend1;
                  end
               end
            end
         end
         ST_SETUP: begin
            if (start_raw >= X_W'(2 * HIST)) begin
               addr_in = ADDR_W'(start_raw - X_W'(2 * HIST));
            end else if (start_raw >= X_W'(HIST)) begin
               addr_in = ADDR_W'(start_raw - X_W'(HIST));
            end else begin
               addr_in = ADDR_W'(start_raw);
            end
            age_in   = $signed(X_W'(cen_age_ff) + X_W'(span));
            col_in   = $signed(X_W'(ctr_col_ff)) - $signed(X_W'(r_eff));
            ki_in    = '0;
            kj_in    = '0;
            acc_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_ok_in = (age_ff >= 0) && (age_ff < $signed(X_W'(fill_ff))) &&
                       (col_ff >= 0) && (col_ff < $signed(X_W'(w_eff)));
            addr_in  = ADDR_W'(addr_sum);
            age_in   = age_ff - step;
            if (ki_ff == two_r) begin
               ki_in  = '0;
               kj_in  = kj_ff + K_W'(1);
               col_in = $signed(X_W'(ctr_col_ff)) - $signed(X_W'(r_eff));
               if (kj_ff == two_r) begin
                  state_in = ST_LAST;
               end
            end else begin
               ki_in  = ki_ff + K_W'(1);
               col_in = col_ff + X_W'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               rsp_row_in   = ctr_row_ff;
               rsp_col_in   = ctr_col_ff;
               if (WW'(ctr_col_ff) + WW'(1) >= w_eff) begin
                  ctr_col_in = '0;
                  ctr_row_in = ctr_row_ff + ROW_BITS'(1);
               end else begin
                  ctr_col_in = ctr_col_ff + COL_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         line_width_ff  <= LINE_WIDTH_RESET;
         radius_ff      <= RADIUS_RESET;
         head_ff        <= '0;
         fill_ff        <= '0;
         pend_ff        <= '0;
         in_col_ff      <= '0;
         in_row_ff      <= '0;
         frame_ended_ff <= 1'b0;
         ctr_col_ff     <= '0;
         ctr_row_ff     <= '0;
         rd_ok_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_width_ff  <= line_width_in;
         radius_ff      <= radius_in;
         head_ff        <= head_in;
         fill_ff        <= fill_in;
         pend_ff        <= pend_in;
         in_col_ff      <= in_col_in;
         in_row_ff      <= in_row_in;
         frame_ended_ff <= frame_ended_in;
         ctr_col_ff     <= ctr_col_in;
         ctr_row_ff     <= ctr_row_in;
         rd_ok_ff       <= rd_ok_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cen_age_ff <= cen_age_in;
      addr_ff    <= addr_in;
      age_ff     <= age_in;
      col_ff     <= col_in;
      ki_ff      <= ki_in;
      kj_ff      <= kj_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
   end

   // pixel history
   zpbs_hist_mem #(
      .DEPTH (HIST),
      .WIDTH (PIXEL_BITS)
   ) u_hist_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (head_ff),
      .wr_data (req_pixel),
      .rd_addr (addr_ff),
      .rd_data (mem_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_sum = rsp_sum_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;

endmodule

@@ src/zpbs_hist_mem.sv @@
// ---------------------------------------------------------------------------
// zpbs_hist_mem
// pixel history memory, one write and one registered read port
// ---------------------------------------------------------------------------
module zpbs_hist_mem #(
   parameter int DEPTH = 521,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ src/zpbs_checker.sv @@
// ---------------------------------------------------------------------------
// zpbs_checker
// port-level checks of the box sum block, bound to the top level
// ---------------------------------------------------------------------------
`include "zero_padded_box_sum_2d_assert.svh"

module zpbs_checker
   import zpbs_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_RADIUS = 4,
   parameter int PIXEL_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_kind,
   input logic signed [PIXEL_BITS-1:0]  req_pixel,
   input logic                          req_frame_start,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [PIXEL_BITS+$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1))-1:0]
                                        rsp_window_sum,
   input logic [ROW_BITS-1:0]           rsp_out_row,
   input logic [$clog2(MAX_WIDTH)-1:0]  rsp_out_col,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [CSR_INDEX_BITS-1:0]     csr_index,
   input logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   // a stalled result holds
   `ZPBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_window_sum) && $stable(rsp_out_row) && $stable(rsp_out_col), "stalled result changed")

   // nothing to deliver straight after reset
   `ZPBS_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid, "result valid after reset")

   // a window sum never appears the cycle after a transfer in
   `ZPBS_ASSERT_NEXT(a_rsp_latency, clock, reset, req_valid && !req_stall, !$rose(rsp_valid), "result too early after item transfer")

   // a control write and an item transfer never share a cycle
   `ZPBS_ASSERT_SAME(a_csr_excl, clock, reset, csr_valid && csr_ready, req_stall, "item taken during control write")

endmodule

bind zero_padded_box_sum_2d zpbs_checker #(
   .MAX_WIDTH  (MAX_WIDTH),
   .MAX_RADIUS (MAX_RADIUS),
   .PIXEL_BITS (PIXEL_BITS)
) u_zpbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_kind        (req_kind),
   .req_pixel       (req_pixel),
   .req_frame_start (req_frame_start),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_window_sum  (rsp_window_sum),
   .rsp_out_row     (rsp_out_row),
   .rsp_out_col     (rsp_out_col),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready),
   .csr_index       (csr_index),
   .csr_wdata       (csr_wdata)
);
